// ===== rtl/att_pkg.sv =====
// ----------------------------------------------------------------------------
// Array tree traversal package
// Item types, command and order codes shared by the traversal unit.
// ----------------------------------------------------------------------------
package att_pkg;

  localparam int NODES_DEF = 63;
  localparam int VALUE_W   = 32;

  localparam logic [1:0] CMD_APPEND   = 2'd0;
  localparam logic [1:0] CMD_TRAVERSE = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  localparam logic [1:0] ORD_LEVEL = 2'd0;
  localparam logic [1:0] ORD_PRE   = 2'd1;
  localparam logic [1:0] ORD_IN    = 2'd2;
  localparam logic [1:0] ORD_POST  = 2'd3;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [VALUE_W-1:0] node_value;
    logic                      node_present;
    logic [1:0]                traverse_order;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic                      out_last;
  } out_item_t;

endpackage

// ===== rtl/array_tree_traversal_unit.sv =====
// ----------------------------------------------------------------------------
// Array tree traversal unit
// Heap-indexed binary tree store with level, pre, in and post order walks.
// ----------------------------------------------------------------------------
// Append, clear and unknown commands are taken while idle. A traverse walks the
// tree with one shared index unit, climbing by parent index (no stack): level
// order scans every stored slot, the depth-first orders only the nodes reached
// from the root. in_ready stays low until the walk ends and its last value has
// moved to the output register; an emit holds while out_ready stalls the output.
// Synchronous active-low reset empties the tree and clears all control state.
module array_tree_traversal_unit #(
  parameter int NODES = att_pkg::NODES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  att_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output att_pkg::out_item_t out_item
);
  import att_pkg::*;

  localparam int CNT_W = $clog2(NODES + 1);
  localparam int CW    = CNT_W + 1;
  localparam int IW    = (NODES > 1) ? $clog2(NODES) : 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_VISIT  = 4'b0010,
    S_EMIT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    PH_ENTER = 3'b001,
    PH_LEFT  = 3'b010,
    PH_RIGHT = 3'b100
  } phase_t;

  state_t                    state_r, state_nxt;
  phase_t                    phase_r, phase_nxt;
  logic [CW-1:0]             cur_r, cur_nxt;
  logic [1:0]                mode_r, mode_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [NODES-1:0]          present_r;
  logic signed [VALUE_W-1:0] node_store [NODES];
  logic signed [VALUE_W-1:0] mem_q;
  logic                      pend_valid_r, pend_valid_nxt;
  logic signed [VALUE_W-1:0] pend_value_r, pend_value_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_item_r, out_item_nxt;

  logic                      in_fire;
  logic                      out_free;
  logic                      can_append;
  logic                      cur_in_range;
  logic                      live;
  logic                      emit_req;
  logic                      go_up;
  logic                      mv_done;
  logic [CW-1:0]             mv_cur;
  phase_t                    mv_phase;
  logic [CW-1:0]             cur_dec;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;
  assign can_append = (count_r < CNT_W'(NODES));

  assign cur_in_range = (cur_r < {1'b0, count_r});
  assign live         = cur_in_range && present_r[cur_r[IW-1:0]];
  assign cur_dec      = cur_r - CW'(1);

  // Walk step: what to emit here and where the index goes next
  always_comb begin
    emit_req = 1'b0;
    go_up    = 1'b0;
    mv_done  = 1'b0;
    mv_cur   = cur_r;
    mv_phase = PH_ENTER;
    if (mode_r == ORD_LEVEL) begin
      if (!cur_in_range) begin
        mv_done = 1'b1;
      end else begin
        emit_req = present_r[cur_r[IW-1:0]];
        mv_cur   = cur_r + CW'(1);
      end
    end else begin
      unique case (phase_r)
        PH_ENTER: begin
          if (live) begin
            emit_req = (mode_r == ORD_PRE);
            mv_cur   = {cur_r[CW-2:0], 1'b1};
          end else begin
            go_up = 1'b1;
          end
        end
        PH_LEFT: begin
          emit_req = (mode_r == ORD_IN);
          mv_cur   = {cur_r[CW-2:0], 1'b0} + CW'(2);
        end
        PH_RIGHT: begin
          emit_req = (mode_r == ORD_POST);
          go_up    = 1'b1;
        end
        default: mv_done = 1'b1;
      endcase
      // climb to the parent; an odd index was a left child
      if (go_up) begin
        if (cur_r == '0) begin
          mv_done = 1'b1;
        end else begin
          mv_cur   = {1'b0, cur_dec[CW-1:1]};
          mv_phase = cur_r[0] ? PH_LEFT : PH_RIGHT;
        end
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    cur_nxt        = cur_r;
    mode_nxt       = mode_r;
    count_nxt      = count_r;
    pend_valid_nxt = pend_valid_r;
    pend_value_nxt = pend_value_r;
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_item.cmd)
            CMD_APPEND: begin
              if (can_append) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_CLEAR: count_nxt = '0;
            CMD_TRAVERSE: begin
              mode_nxt  = in_item.traverse_order;
              cur_nxt   = '0;
              phase_nxt = PH_ENTER;
              state_nxt = S_VISIT;
            end
            default: ;
          endcase
        end
      end
      S_VISIT: begin
        if (emit_req) begin
          state_nxt = S_EMIT;
        end else if (mv_done) begin
          state_nxt = S_FINISH;
        end else begin
          cur_nxt   = mv_cur;
          phase_nxt = mv_phase;
        end
      end
      S_EMIT: begin
        // hold until the previous value can move to the output register
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt          = 1'b1;
            out_item_nxt.out_value = pend_value_r;
            out_item_nxt.out_last  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_value_nxt = mem_q;
          if (mv_done) begin
            state_nxt = S_FINISH;
          end else begin
            cur_nxt   = mv_cur;
            phase_nxt = mv_phase;
            state_nxt = S_VISIT;
          end
        end
      end
      S_FINISH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.out_value = pend_value_r;
          out_item_nxt.out_last  = 1'b1;
          pend_valid_nxt         = 1'b0;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_ENTER;
      cur_r        <= '0;
      mode_r       <= ORD_LEVEL;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      cur_r        <= cur_nxt;
      mode_r       <= mode_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_value_r <= pend_value_nxt;
    out_item_r   <= out_item_nxt;
  end

  // Present bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (in_fire && in_item.cmd == CMD_CLEAR) begin
      present_r <= '0;
    end else if (in_fire && in_item.cmd == CMD_APPEND && can_append) begin
      present_r[count_r[IW-1:0]] <= in_item.node_present;
    end
  end

  // Node value memory
  always_ff @(posedge clk) begin
    if (in_fire && in_item.cmd == CMD_APPEND && can_append) begin
      node_store[count_r[IW-1:0]] <= in_item.node_value;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= node_store[cur_r[IW-1:0]];
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NODES))
    else $error("node count beyond capacity");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_valid_r)
    else $error("pending value left behind after a traversal");

  a_emit_stored: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> cur_r < {1'b0, count_r})
    else $error("emit from a slot that was never appended");

  a_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && pend_valid_r && !out_free)
      |=> (state_r == S_EMIT && $stable(cur_r)))
    else $error("walk advanced while output was blocked");
`endif

endmodule

// ===== bench/array_tree_traversal_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Array tree traversal unit testbench
// Drives append, traverse, clear and unknown commands through the input
// channel, predicts every visited node value and last flag from a private
// copy of the tree, and checks each result in order. Both sides idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module array_tree_traversal_unit_tb;
  import att_pkg::*;

  localparam int NODES          = att_pkg::NODES_DEF;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int ITEM_TARGET    = 220;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic [1:0] {STEP_LEFT, STEP_RIGHT, STEP_UP} walk_step_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // private copy of the tree
  logic signed [VALUE_W-1:0] tree_val [0:NODES-1];
  logic                      tree_here [0:NODES-1];
  int                        tree_len = 0;

  in_item_t  pending_q [$];
  out_item_t visit_q [$];

  int tx_wait = 0;
  int tx_calm = 0;
  int rx_wait = 0;
  int rx_calm = 0;
  int items_taken = 0;
  int mismatches = 0;
  int quiet = 0;
  int hold_count = 0;
  logic rx_hold = 1'b0;
  logic hold_done = 1'b0;
  int planned = 0;

  array_tree_traversal_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit is_live(int idx);
    return idx < tree_len && idx < NODES && tree_here[idx];
  endfunction

  // Update the tree copy and queue the node values a traverse will visit.
  function automatic void apply_item(in_item_t it);
    int         stk_idx [0:NODES-1];
    walk_step_t stk_step [0:NODES-1];
    int         sp;
    int         idx;
    out_item_t  seen [$];
    out_item_t  r;
    case (it.cmd)
      CMD_APPEND: begin
        if (tree_len < NODES) begin
          tree_val[tree_len] = it.node_value;
          tree_here[tree_len] = it.node_present;
          tree_len++;
        end
      end
      CMD_CLEAR: begin
        tree_len = 0;
        for (int i = 0; i < NODES; i++) tree_here[i] = 1'b0;
      end
      CMD_TRAVERSE: begin
        if (it.traverse_order == ORD_LEVEL) begin
          for (int i = 0; i < tree_len; i++) begin
            if (tree_here[i]) begin
              r.out_value = tree_val[i];
              r.out_last = 1'b0;
              seen = {seen, r};
            end
          end
        end else begin
          sp = 0;
          if (is_live(0)) begin
            stk_idx[0] = 0;
            stk_step[0] = STEP_LEFT;
            sp = 1;
          end
          while (sp > 0) begin
            idx = stk_idx[sp-1];
            r.out_value = tree_val[idx];
            r.out_last = 1'b0;
            case (stk_step[sp-1])
              STEP_LEFT: begin
                if (it.traverse_order == ORD_PRE) seen = {seen, r};
                stk_step[sp-1] = STEP_RIGHT;
                if (is_live(2 * idx + 1)) begin
                  stk_idx[sp] = 2 * idx + 1;
                  stk_step[sp] = STEP_LEFT;
                  sp++;
                end
              end
              STEP_RIGHT: begin
                if (it.traverse_order == ORD_IN) seen = {seen, r};
                stk_step[sp-1] = STEP_UP;
                if (is_live(2 * idx + 2)) begin
                  stk_idx[sp] = 2 * idx + 2;
                  stk_step[sp] = STEP_LEFT;
                  sp++;
                end
              end
              default: begin
                if (it.traverse_order == ORD_POST) seen = {seen, r};
                sp--;
              end
            endcase
          end
        end
        if (seen.size() > 0) seen[seen.size()-1].out_last = 1'b1;
        foreach (seen[i]) visit_q = {visit_q, seen[i]};
      end
      default: ;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_item(logic [1:0] c, logic [VALUE_W-1:0] v, logic p, logic [1:0] o);
    in_item_t it;
    it.cmd = c;
    it.node_value = v;
    it.node_present = p;
    it.traverse_order = o;
    pending_q = {pending_q, it};
    if (c != CMD_NONE) planned++;
  endtask

  task automatic add_append(int pct_present);
    add_item(CMD_APPEND, rand_value(), $urandom_range(0, 99) < pct_present,
             2'($urandom_range(0, 3)));
  endtask

  task automatic add_traverse();
    add_item(CMD_TRAVERSE, $urandom(), 1'($urandom_range(0, 1)),
             2'($urandom_range(0, 3)));
  endtask

  // Driver: present the next pending item, idling a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
      tx_calm <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        apply_item(in_item);
        items_taken <= items_taken + 1;
      end
      if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (pending_q.size() > 0) begin
        in_item <= pending_q.pop_front();
        in_valid <= 1'b1;
        if (tx_calm > 0) begin
          tx_wait <= 0;
          tx_calm <= tx_calm - 1;
        end else if ($urandom_range(0, 15) == 0) begin
          tx_wait <= 0;
          tx_calm <= 30;
        end else begin
          tx_wait <= $urandom_range(0, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result against the oldest expected node value.
  always @(posedge clk) begin : monitor
    int        pause;
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
      rx_calm <= 0;
    end else begin
      pause = (rx_wait > 0) ? rx_wait - 1 : 0;
      if (out_valid && out_ready) begin
        if (visit_q.size() == 0) begin
          $error("unexpected result: out_value %0d out_last %0b",
                 out_item.out_value, out_item.out_last);
          mismatches++;
        end else begin
          want = visit_q.pop_front();
          if (out_item.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, out_item.out_value);
            mismatches++;
          end
          if (out_item.out_last !== want.out_last) begin
            $error("out_last: expected %0b, got %0b", want.out_last, out_item.out_last);
            mismatches++;
          end
        end
        if (rx_calm > 0) begin
          pause = 0;
          rx_calm <= rx_calm - 1;
        end else if ($urandom_range(0, 15) == 0) begin
          pause = 0;
          rx_calm <= 40;
        end else begin
          pause = $urandom_range(0, 6);
        end
      end
      rx_wait <= pause;
      out_ready <= (pause == 0) && !rx_hold;
    end
  end

  // Hold off the receiver once while a traverse is in flight.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold <= 1'b0;
      hold_done <= 1'b0;
      hold_count <= 0;
    end else if (rx_hold) begin
      if (hold_count == HOLD_CYCLES) rx_hold <= 1'b0;
      hold_count <= hold_count + 1;
    end else if (!hold_done && out_valid && items_taken >= 40) begin
      rx_hold <= 1'b1;
      hold_done <= 1'b1;
      hold_count <= 0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int  n;
    bit  big_done;
    big_done = 1'b0;

    // empty tree, extremes, all orders, absent slots, unknown command
    add_item(CMD_TRAVERSE, 32'h0, 1'b1, ORD_LEVEL);
    add_item(CMD_TRAVERSE, 32'h0, 1'b1, ORD_PRE);
    add_item(CMD_APPEND, 32'h7fff_ffff, 1'b1, ORD_POST);
    add_item(CMD_APPEND, 32'h8000_0000, 1'b1, ORD_LEVEL);
    add_item(CMD_APPEND, 32'h0000_0000, 1'b0, ORD_IN);
    add_item(CMD_APPEND, 32'hffff_ffff, 1'b1, ORD_PRE);
    add_item(CMD_APPEND, 32'd12345, 1'b1, ORD_LEVEL);
    add_item(CMD_TRAVERSE, 32'hffff_ffff, 1'b0, ORD_LEVEL);
    add_item(CMD_TRAVERSE, 32'h0, 1'b1, ORD_PRE);
    add_item(CMD_TRAVERSE, 32'h5555_aaaa, 1'b0, ORD_IN);
    add_item(CMD_TRAVERSE, 32'h0, 1'b1, ORD_POST);
    add_item(CMD_NONE, 32'hffff_ffff, 1'b1, ORD_POST);
    add_item(CMD_TRAVERSE, 32'h0, 1'b0, ORD_IN);
    add_item(CMD_CLEAR, 32'hffff_ffff, 1'b1, ORD_POST);
    add_item(CMD_TRAVERSE, 32'h0, 1'b1, ORD_POST);
    // absent root hides the whole tree from the depth-first walks
    add_item(CMD_APPEND, 32'd55, 1'b0, ORD_LEVEL);
    add_item(CMD_APPEND, 32'd66, 1'b1, ORD_LEVEL);
    add_item(CMD_TRAVERSE, 32'h0, 1'b1, ORD_PRE);
    add_item(CMD_TRAVERSE, 32'h0, 1'b1, ORD_LEVEL);
    add_item(CMD_TRAVERSE, 32'h0, 1'b1, ORD_IN);
    add_item(CMD_CLEAR, 32'h0, 1'b0, ORD_LEVEL);
    add_item(CMD_APPEND, 32'd1, 1'b1, ORD_LEVEL);
    add_item(CMD_TRAVERSE, 32'h0, 1'b1, ORD_POST);
    add_item(CMD_CLEAR, 32'h0, 1'b0, ORD_LEVEL);

    while (planned < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        7: begin
          if (!big_done && planned > 90) begin
            // fill past capacity: the extra appends are dropped
            big_done = 1'b1;
            add_item(CMD_CLEAR, $urandom(), 1'b1, 2'($urandom_range(0, 3)));
            for (int i = 0; i < NODES + 3; i++) add_append(92);
            add_traverse();
            add_traverse();
            add_item(CMD_TRAVERSE, $urandom(), 1'b1, ORD_LEVEL);
          end
        end
        8: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++)
            add_item(2'($urandom_range(0, 3)), rand_value(), 1'($urandom_range(0, 1)),
                     2'($urandom_range(0, 3)));
        end
        9: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) add_append(80);
          add_traverse();
        end
        default: begin
          add_item(CMD_CLEAR, $urandom(), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)));
          n = $urandom_range(1, 14);
          for (int i = 0; i < n; i++) add_append(85);
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0)
              add_item(CMD_NONE, $urandom(), 1'($urandom_range(0, 1)),
                       2'($urandom_range(0, 3)));
            add_traverse();
          end
        end
      endcase
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || visit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/att_pkg.sv
rtl/array_tree_traversal_unit.sv
bench/array_tree_traversal_unit_tb.sv
